[rtl/gclp_pkg.sv]
package gclp_pkg;

  localparam int NAME_BUFFER_BYTES = 32;
  localparam int IDX_W = $clog2(NAME_BUFFER_BYTES);
  localparam int CNT_W = $clog2(NAME_BUFFER_BYTES + 1);
  localparam int LEN_W = 5;
  localparam int OFF_W = 32;
  localparam int CHAR_W = 8;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_NAME = 1'b1;

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_FIRST_DIGIT = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_SPACES = 3'd3;
  localparam logic [2:0] PH_NAME = 3'd4;

  localparam logic [2:0] PREFIX_LEN = 3'd5;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;

  function automatic logic [CHAR_W-1:0] prefix_byte(input logic [2:0] pos);
    logic [CHAR_W-1:0] b;
    case (pos)
      3'd0: b = 8'h47;
      3'd1: b = 8'h45;
      3'd2: b = 8'h54;
      3'd3: b = 8'h32;
      3'd4: b = CHAR_SPACE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/gclp_ram.sv]
module gclp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/get_command_line_parser.sv]
// channel  | signals                                              | dir
// ---------+------------------------------------------------------+-----
// in       | in_valid, in_stall, char_code                        | in
// out      | out_valid, out_stall, item_kind, accepted,           | out
//          | offset_value, name_length, name_byte, last_of_run    |
//
// A byte that is not the terminator yields no result.
// The terminator yields one header; on acceptance each filename byte then
// passes through a name buffer read and an output register load, and the
// input stalls after an accepted line until its last filename byte is loaded.
// Reset clears the parser state; the name buffer needs no clearing.
// A stalled output holds its register and stalls the input in turn.
module get_command_line_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gclp_pkg::CHAR_W-1:0]  char_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         item_kind,
  output logic                         accepted,
  output logic [gclp_pkg::OFF_W-1:0]   offset_value,
  output logic [gclp_pkg::LEN_W-1:0]   name_length,
  output logic [gclp_pkg::CHAR_W-1:0]  name_byte,
  output logic                         last_of_run
);

  localparam logic [1:0] ST_PARSE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] parse_phase, parse_phase_next;
  logic [2:0] prefix_position, prefix_position_next;
  logic [gclp_pkg::OFF_W-1:0] offset_accumulator, offset_accumulator_next;
  logic line_rejected, line_rejected_next;
  logic previous_was_dot, previous_was_dot_next;
  logic [gclp_pkg::CNT_W-1:0] name_count, name_count_next;
  logic [gclp_pkg::IDX_W-1:0] rd_idx, rd_idx_next;
  logic [gclp_pkg::CNT_W-1:0] emit_len, emit_len_next;

  logic out_free, in_fire, is_digit, name_ok, is_dot, line_ok, rd_last;
  logic [gclp_pkg::OFF_W+3:0] mul_sum;
  logic wr_en;
  logic [gclp_pkg::CHAR_W-1:0] rd_data;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_PARSE) || !out_free;
  assign in_fire = in_valid && !in_stall;

  assign is_digit = char_code inside {[8'h30:8'h39]};
  assign name_ok = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                                     8'h2D, 8'h5F, gclp_pkg::CHAR_DOT};
  assign is_dot = char_code == gclp_pkg::CHAR_DOT;
  assign mul_sum = {1'b0, offset_accumulator, 3'b000} + {3'b000, offset_accumulator, 1'b0}
                   + {{(gclp_pkg::OFF_W){1'b0}}, char_code[3:0]};
  assign line_ok = !line_rejected && parse_phase == gclp_pkg::PH_NAME && name_count != '0
                   && name_count < gclp_pkg::CNT_W'(gclp_pkg::NAME_BUFFER_BYTES);
  assign rd_last = (gclp_pkg::CNT_W'(rd_idx) + gclp_pkg::CNT_W'(1)) == emit_len;

  gclp_ram #(
    .WIDTH(gclp_pkg::CHAR_W),
    .DEPTH(gclp_pkg::NAME_BUFFER_BYTES)
  ) u_name_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(name_count[gclp_pkg::IDX_W-1:0]),
    .wr_data(char_code),
    .rd_en(state == ST_READ),
    .rd_addr(rd_idx),
    .rd_data(rd_data)
  );

  always_comb begin
    logic take_name;
    take_name = 1'b0;
    state_next = state;
    parse_phase_next = parse_phase;
    prefix_position_next = prefix_position;
    offset_accumulator_next = offset_accumulator;
    line_rejected_next = line_rejected;
    previous_was_dot_next = previous_was_dot;
    name_count_next = name_count;
    rd_idx_next = rd_idx;
    emit_len_next = emit_len;
    wr_en = 1'b0;

    case (state)
      ST_PARSE: begin
        if (in_fire) begin
          if (char_code == '0) begin
            parse_phase_next = gclp_pkg::PH_PREFIX;
            prefix_position_next = '0;
            offset_accumulator_next = '0;
            line_rejected_next = 1'b0;
            previous_was_dot_next = 1'b0;
            name_count_next = '0;
            if (line_ok) begin
              emit_len_next = name_count;
              rd_idx_next = '0;
              state_next = ST_READ;
            end
          end else if (!line_rejected) begin
            case (parse_phase)
              gclp_pkg::PH_PREFIX: begin
                if (char_code == gclp_pkg::prefix_byte(prefix_position)) begin
                  prefix_position_next = prefix_position + 3'd1;
                  if (prefix_position + 3'd1 == gclp_pkg::PREFIX_LEN) begin
                    parse_phase_next = gclp_pkg::PH_FIRST_DIGIT;
                  end
                end else begin
                  line_rejected_next = 1'b1;
                end
              end
              gclp_pkg::PH_FIRST_DIGIT, gclp_pkg::PH_DIGITS: begin
                if (is_digit) begin
                  if (|mul_sum[gclp_pkg::OFF_W+3:gclp_pkg::OFF_W]) begin
                    line_rejected_next = 1'b1;
                  end else begin
                    offset_accumulator_next = mul_sum[gclp_pkg::OFF_W-1:0];
                  end
                  parse_phase_next = gclp_pkg::PH_DIGITS;
                end else if (parse_phase == gclp_pkg::PH_DIGITS
                             && char_code == gclp_pkg::CHAR_SPACE) begin
                  parse_phase_next = gclp_pkg::PH_SPACES;
                end else begin
                  line_rejected_next = 1'b1;
                end
              end
              gclp_pkg::PH_SPACES: begin
                if (char_code != gclp_pkg::CHAR_SPACE) begin
                  parse_phase_next = gclp_pkg::PH_NAME;
                  take_name = 1'b1;
                end
              end
              gclp_pkg::PH_NAME: begin
                take_name = 1'b1;
              end
              default: begin
                line_rejected_next = 1'b1;
              end
            endcase
            if (take_name) begin
              if (!name_ok || (is_dot && (name_count == '0 || previous_was_dot))) begin
                line_rejected_next = 1'b1;
              end else begin
                wr_en = 1'b1;
                name_count_next = name_count + gclp_pkg::CNT_W'(1);
                previous_was_dot_next = is_dot;
                if (name_count + gclp_pkg::CNT_W'(1)
                    >= gclp_pkg::CNT_W'(gclp_pkg::NAME_BUFFER_BYTES)) begin
                  line_rejected_next = 1'b1;
                end
              end
            end
          end
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          if (rd_last) begin
            state_next = ST_PARSE;
          end else begin
            rd_idx_next = rd_idx + gclp_pkg::IDX_W'(1);
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PARSE;
      parse_phase <= gclp_pkg::PH_PREFIX;
      prefix_position <= '0;
      offset_accumulator <= '0;
      line_rejected <= 1'b0;
      previous_was_dot <= 1'b0;
      name_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      parse_phase <= parse_phase_next;
      prefix_position <= prefix_position_next;
      offset_accumulator <= offset_accumulator_next;
      line_rejected <= line_rejected_next;
      previous_was_dot <= previous_was_dot_next;
      name_count <= name_count_next;
      if (state == ST_PARSE && in_fire && char_code == '0) begin
        out_valid <= 1'b1;
      end else if (state == ST_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    emit_len <= emit_len_next;
    if (state == ST_PARSE && in_fire && char_code == '0) begin
      item_kind <= gclp_pkg::KIND_HEADER;
      accepted <= line_ok;
      offset_value <= line_ok ? offset_accumulator : '0;
      name_length <= line_ok ? gclp_pkg::LEN_W'(name_count) : '0;
      name_byte <= '0;
      last_of_run <= !line_ok;
    end else if (state == ST_LOAD && out_free) begin
      item_kind <= gclp_pkg::KIND_NAME;
      accepted <= 1'b1;
      offset_value <= '0;
      name_length <= '0;
      name_byte <= rd_data;
      last_of_run <= rd_last;
    end
  end

endmodule
